// ===== src/easing_curve_interpolator_unit_macros.svh =====
// Assertion macros shared by the easing curve interpolator RTL.
// Each macro expects clk and rst in scope.
`ifndef EASING_CURVE_INTERPOLATOR_UNIT_MACROS_SVH
`define EASING_CURVE_INTERPOLATOR_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ECI_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define ECI_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is seen.
`define ECI_ASSERT_RST(label, post, msg) \
  label: assert property (@(posedge clk) rst |=> (post)) \
    else $error(msg);

`endif

// ===== src/eci_pkg.sv =====
// ----------------------------------------------------------------------------
// eci_pkg
// Curve codes, fixed constants and the lane control struct of the easing
// curve interpolator.
// ----------------------------------------------------------------------------
package eci_pkg;

  localparam int FUNC_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_LINEAR      = 3'd0,
    FN_QUAD_IN     = 3'd1,
    FN_QUAD_OUT    = 3'd2,
    FN_QUAD_INOUT  = 3'd3,
    FN_SINE_IN     = 3'd4,
    FN_SINE_OUT    = 3'd5,
    FN_SINE_INOUT  = 3'd6
  } func_t;

  typedef struct packed {
    func_t func;
    logic  done;
    logic  hold_start;
  } lane_ctl_t;

  localparam logic [15:0] T_FULL       = 16'd100;
  localparam logic [15:0] T_TWO        = 16'd200;
  localparam logic [15:0] T_SQ         = 16'd10000;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;
  localparam logic [15:0] HALF_TURN    = 16'h8000;
  localparam logic [15:0] HALF_RATIO   = 16'd32767;
  localparam logic [16:0] RATIO_MAX    = 17'd65535;

  localparam int SIN_Q_W  = 29;
  localparam int SIN_NW   = 47;
  localparam int SIN_DW   = 31;
  localparam logic [17:0] SIN_NUM_K = 18'd262140;
  localparam logic [30:0] SIN_DEN_K = 31'd1342177280;

endpackage

// ===== src/eci_ifs.sv =====
// ----------------------------------------------------------------------------
// eci_ifs
// Valid/ready channels for the input item and the result point.
// ----------------------------------------------------------------------------
interface eci_in_if #(
  parameter int COORD_BITS    = 16,
  parameter int PROGRESS_BITS = 16
);
  logic                                valid;
  logic                                ready;
  logic [eci_pkg::FUNC_W-1:0]          func;
  logic [PROGRESS_BITS-1:0]            progress;
  logic [PROGRESS_BITS-1:0]            progress_max;
  logic signed [COORD_BITS-1:0]        start_x;
  logic signed [COORD_BITS-1:0]        start_y;
  logic signed [COORD_BITS-1:0]        end_x;
  logic signed [COORD_BITS-1:0]        end_y;

  modport source (output valid, func, progress, progress_max, start_x, start_y,
                  end_x, end_y, input ready);
  modport sink (input valid, func, progress, progress_max, start_x, start_y,
                end_x, end_y, output ready);
endinterface

interface eci_out_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink (input valid, point_x, point_y, output ready);
endinterface

// ===== src/eci_div.sv =====
// ----------------------------------------------------------------------------
// eci_div
// Pipelined restoring divider, one quotient bit per stage, with a tag that
// travels alongside. All stages advance together on en.
// ----------------------------------------------------------------------------
module eci_div #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          load,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] tag,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] tag_q
);

  logic          vld [NW];
  logic [DW-1:0] rem [NW];
  logic [NW-1:0] acc [NW];
  logic [DW-1:0] dv  [NW];
  logic [SW-1:0] tg  [NW];

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] r_in;
    logic [NW-1:0] a_in;
    logic [DW-1:0] d_in;
    logic [SW-1:0] t_in;
    logic [DW:0]   trial;
    logic          fit;

    if (g == 0) begin : g_first
      assign v_in = load;
      assign r_in = '0;
      assign a_in = num;
      assign d_in = den;
      assign t_in = tag;
    end else begin : g_next
      assign v_in = vld[g-1];
      assign r_in = rem[g-1];
      assign a_in = acc[g-1];
      assign d_in = dv[g-1];
      assign t_in = tg[g-1];
    end

    assign trial = {r_in, a_in[NW-1]};
    assign fit   = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g] <= fit ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];
        acc[g] <= {a_in[NW-2:0], fit};
        dv[g]  <= d_in;
        tg[g]  <= t_in;
      end
    end
  end

  assign done  = vld[NW-1];
  assign quo   = acc[NW-1];
  assign tag_q = tg[NW-1];

endmodule

// ===== src/eci_lane.sv =====
// ----------------------------------------------------------------------------
// eci_lane
// One coordinate lane: scales the curve factor by the distance, divides
// with truncation toward zero, adds the base point and saturates.
// ----------------------------------------------------------------------------
module eci_lane #(
  parameter int CB  = 16,
  parameter int MW  = 17,
  parameter int DNW = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    load,
  input  eci_pkg::lane_ctl_t      ctl,
  input  logic [MW-1:0]           mv,
  input  logic [DNW-1:0]          den,
  input  logic signed [CB-1:0]    from,
  input  logic signed [CB-1:0]    to,
  output logic                    done,
  output logic signed [CB-1:0]    point
);

  localparam int PRW  = CB + MW + 2;
  localparam int MAGW = CB + MW + 1;
  localparam int SUMW = CB + 3;

  localparam logic signed [SUMW-1:0] SAT_HI = {3'b000, 1'b0, {(CB-1){1'b1}}};
  localparam logic signed [SUMW-1:0] SAT_LO = {3'b111, 1'b1, {(CB-1){1'b0}}};

  typedef struct packed {
    eci_pkg::lane_ctl_t    ctl;
    logic                  neg;
    logic signed [CB-1:0]  from;
    logic signed [CB-1:0]  to;
  } tag_t;

  logic signed [CB:0]    d;
  logic signed [CB:0]    dd;
  logic signed [CB:0]    h;
  logic signed [CB:0]    coef;
  logic signed [PRW-1:0] prod;

  always_comb begin
    d  = {to[CB-1], to} - {from[CB-1], from};
    dd = d + {{CB{1'b0}}, d[CB]};
    h  = dd >>> 1;
    unique case (ctl.func)
      eci_pkg::FN_QUAD_INOUT,
      eci_pkg::FN_SINE_OUT,
      eci_pkg::FN_SINE_INOUT: coef = h;
      eci_pkg::FN_SINE_IN:    coef = -h;
      default:                coef = d;
    endcase
    prod = coef * $signed({1'b0, mv});
  end

  logic                  f_v;
  logic signed [PRW-1:0] f_prod;
  eci_pkg::lane_ctl_t    f_ctl;
  logic [DNW-1:0]        f_den;
  logic signed [CB-1:0]  f_from;
  logic signed [CB-1:0]  f_to;

  logic                  g_v;
  logic [MAGW-1:0]       g_mag;
  logic [DNW-1:0]        g_den;
  tag_t                  g_tag;

  logic [PRW-1:0]        f_abs;
  assign f_abs = f_prod[PRW-1] ? PRW'(-f_prod) : PRW'(f_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
      g_v <= 1'b0;
    end else if (en) begin
      f_v <= load;
      g_v <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_prod     <= prod;
      f_ctl      <= ctl;
      f_den      <= den;
      f_from     <= from;
      f_to       <= to;
      g_mag      <= f_abs[MAGW-1:0];
      g_den      <= f_den;
      g_tag.ctl  <= f_ctl;
      g_tag.neg  <= f_prod[PRW-1];
      g_tag.from <= f_from;
      g_tag.to   <= f_to;
    end
  end

  logic            q_v;
  logic [MAGW-1:0] q;
  tag_t            q_tag;

  eci_div #(
    .NW (MAGW),
    .DW (DNW),
    .SW ($bits(tag_t))
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .load  (g_v),
    .num   (g_mag),
    .den   (g_den),
    .tag   (g_tag),
    .done  (q_v),
    .quo   (q),
    .tag_q (q_tag)
  );

  logic signed [SUMW-1:0] qs;
  logic signed [SUMW-1:0] base;
  logic signed [SUMW-1:0] sum;
  logic signed [CB-1:0]   point_next;

  always_comb begin
    qs   = q_tag.neg ? -$signed({1'b0, q[CB+1:0]}) : $signed({1'b0, q[CB+1:0]});
    base = (q_tag.ctl.func == eci_pkg::FN_SINE_IN) ? SUMW'(q_tag.to) : SUMW'(q_tag.from);
    sum  = base + qs;
    priority if (q_tag.ctl.done) begin
      point_next = q_tag.to;
    end else if (q_tag.ctl.hold_start) begin
      point_next = q_tag.from;
    end else if (sum > SAT_HI) begin
      point_next = SAT_HI[CB-1:0];
    end else if (sum < SAT_LO) begin
      point_next = SAT_LO[CB-1:0];
    end else begin
      point_next = sum[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else if (en) begin
      done <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      point <= point_next;
    end
  end

endmodule

// ===== src/easing_curve_interpolator_unit.sv =====
// Throughput: one item per cycle while the skid entry is empty; the ratio, sine
// and lane dividers are fully pipelined, one quotient bit per stage. A two-entry
// output buffer decouples.
// Reset: synchronous, clears all valid flags; data registers are not reset.
// ----------------------------------------------------------------------------
// easing_curve_interpolator_unit
// Shared front end computes the progress ratio and the sine factor; two
// coordinate lanes scale and divide; the output stage merges both lanes.
// ----------------------------------------------------------------------------
`include "easing_curve_interpolator_unit_macros.svh"

module easing_curve_interpolator_unit #(
  parameter int COORD_BITS    = 16,
  parameter int PROGRESS_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  eci_in_if.sink    item,
  eci_out_if.source result
);

  localparam int CB  = COORD_BITS;
  localparam int PB  = PROGRESS_BITS;
  localparam int NW1 = PB + 16;
  localparam int MW  = (PB > 17) ? PB : 17;
  localparam int DNW = (PB > 16) ? PB : 16;

  typedef struct packed {
    eci_pkg::lane_ctl_t   ctl;
    logic [PB-1:0]        p;
    logic [PB-1:0]        m;
    logic signed [CB-1:0] sx;
    logic signed [CB-1:0] sy;
    logic signed [CB-1:0] ex;
    logic signed [CB-1:0] ey;
  } ptag_t;

  typedef struct packed {
    ptag_t      base;
    logic [7:0] t;
    logic       neg;
  } stag_t;

  logic en;
  logic out_v;
  logic skid_v;

  assign en         = !skid_v;
  assign item.ready = en;

  // front: ratio division
  eci_pkg::func_t  in_fn;
  logic            in_q3;
  logic [PB-1:0]   in_den;
  logic [NW1-1:0]  in_num;
  ptag_t           in_tag;

  always_comb begin
    in_fn  = eci_pkg::func_t'(item.func);
    in_q3  = in_fn == eci_pkg::FN_QUAD_INOUT;
    in_den = in_q3 ? {1'b0, item.progress_max[PB-1:1]} : item.progress_max;
    if (in_fn == eci_pkg::FN_SINE_IN || in_fn == eci_pkg::FN_SINE_OUT ||
        in_fn == eci_pkg::FN_SINE_INOUT) begin
      in_num = {item.progress, 16'h0000};
    end else begin
      in_num = NW1'(NW1'(item.progress) * NW1'(eci_pkg::T_FULL));
    end
    in_tag.ctl.func       = in_fn;
    in_tag.ctl.done       = item.progress >= item.progress_max;
    in_tag.ctl.hold_start = in_q3 && (item.progress_max[PB-1:1] == '0);
    in_tag.p              = item.progress;
    in_tag.m              = item.progress_max;
    in_tag.sx             = item.start_x;
    in_tag.sy             = item.start_y;
    in_tag.ex             = item.end_x;
    in_tag.ey             = item.end_y;
  end

  logic           r_v;
  logic [NW1-1:0] r_quo;
  ptag_t          r_tag;

  eci_div #(
    .NW (NW1),
    .DW (PB),
    .SW ($bits(ptag_t))
  ) u_ratio_div (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .load  (item.valid),
    .num   (in_num),
    .den   (in_den),
    .tag   (in_tag),
    .done  (r_v),
    .quo   (r_quo),
    .tag_q (r_tag)
  );

  // front: sine argument, quadratic term, numerator and denominator
  logic [15:0] aq;
  logic [15:0] a6;
  logic [15:0] arg_next;
  logic        neg_next;

  always_comb begin
    aq       = {2'b00, r_quo[15:2]};
    a6       = {1'b0, r_quo[15:1]};
    neg_next = 1'b0;
    unique case (r_tag.ctl.func)
      eci_pkg::FN_SINE_IN:  arg_next = aq + eci_pkg::QUARTER_TURN;
      eci_pkg::FN_SINE_OUT: arg_next = aq;
      eci_pkg::FN_SINE_INOUT: begin
        if (a6 <= eci_pkg::QUARTER_TURN) begin
          arg_next = a6 + eci_pkg::QUARTER_TURN;
        end else begin
          arg_next = a6 - eci_pkg::QUARTER_TURN;
          neg_next = 1'b1;
        end
      end
      default: arg_next = '0;
    endcase
  end

  logic                          b_v, c_v, d_v;
  stag_t                         b_tag, c_tag, d_tag;
  logic [15:0]                   b_arg;
  logic [eci_pkg::SIN_Q_W-1:0]   c_q;
  logic [eci_pkg::SIN_NW-1:0]    d_num;
  logic [eci_pkg::SIN_DW-1:0]    d_den;
  logic [15:0]                   c_comp;

  assign c_comp = eci_pkg::HALF_TURN - b_arg;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
    end else if (en) begin
      b_v <= r_v;
      c_v <= b_v;
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_tag.base <= r_tag;
      b_tag.t    <= r_quo[7:0];
      b_tag.neg  <= neg_next;
      b_arg      <= arg_next;
      c_tag      <= b_tag;
      c_q        <= eci_pkg::SIN_Q_W'(32'(b_arg) * 32'(c_comp));
      d_tag      <= c_tag;
      d_num      <= eci_pkg::SIN_NW'(eci_pkg::SIN_NW'(c_q) *
                                     eci_pkg::SIN_NW'(eci_pkg::SIN_NUM_K));
      d_den      <= eci_pkg::SIN_DEN_K - eci_pkg::SIN_DW'(c_q);
    end
  end

  logic                       s_v;
  logic [eci_pkg::SIN_NW-1:0] s_quo;
  stag_t                      s_tag;

  eci_div #(
    .NW (eci_pkg::SIN_NW),
    .DW (eci_pkg::SIN_DW),
    .SW ($bits(stag_t))
  ) u_sine_div (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .load  (d_v),
    .num   (d_num),
    .den   (d_den),
    .tag   (d_tag),
    .done  (s_v),
    .quo   (s_quo),
    .tag_q (s_tag)
  );

  // front: curve factor and divisor for the lanes
  logic [15:0]    t16, u16, tt, tq, kk;
  logic [16:0]    sv;
  logic [MW-1:0]  mv_next;
  logic [DNW-1:0] den_next;

  always_comb begin
    t16 = {8'h00, s_tag.t};
    u16 = t16 - eci_pkg::T_FULL;
    tt  = 16'(t16 * t16);
    tq  = 16'(t16 * (eci_pkg::T_TWO - t16));
    kk  = 16'(u16 * (eci_pkg::T_TWO - u16)) + eci_pkg::T_SQ;
    sv  = {1'b0, s_quo[15:0]};
    unique case (s_tag.base.ctl.func)
      eci_pkg::FN_QUAD_IN: begin
        mv_next  = MW'(tt);
        den_next = DNW'(eci_pkg::T_SQ);
      end
      eci_pkg::FN_QUAD_OUT: begin
        mv_next  = MW'(tq);
        den_next = DNW'(eci_pkg::T_SQ);
      end
      eci_pkg::FN_QUAD_INOUT: begin
        mv_next  = (t16 < eci_pkg::T_FULL) ? MW'(tt) : MW'(kk);
        den_next = DNW'(eci_pkg::T_SQ);
      end
      eci_pkg::FN_SINE_IN, eci_pkg::FN_SINE_OUT: begin
        mv_next  = MW'(sv);
        den_next = DNW'(eci_pkg::HALF_RATIO);
      end
      eci_pkg::FN_SINE_INOUT: begin
        mv_next  = s_tag.neg ? MW'(eci_pkg::RATIO_MAX + sv) : MW'(eci_pkg::RATIO_MAX - sv);
        den_next = DNW'(eci_pkg::RATIO_MAX);
      end
      default: begin
        mv_next  = MW'(s_tag.base.p);
        den_next = DNW'(s_tag.base.m);
      end
    endcase
  end

  logic           e_v;
  ptag_t          e_tag;
  logic [MW-1:0]  e_mv;
  logic [DNW-1:0] e_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en) begin
      e_v <= s_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_tag <= s_tag.base;
      e_mv  <= mv_next;
      e_den <= den_next;
    end
  end

  // lanes
  logic                 x_v, y_v;
  logic signed [CB-1:0] x_pt, y_pt;

  eci_lane #(.CB(CB), .MW(MW), .DNW(DNW)) u_lane_x (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .load  (e_v),
    .ctl   (e_tag.ctl),
    .mv    (e_mv),
    .den   (e_den),
    .from  (e_tag.sx),
    .to    (e_tag.ex),
    .done  (x_v),
    .point (x_pt)
  );

  eci_lane #(.CB(CB), .MW(MW), .DNW(DNW)) u_lane_y (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .load  (e_v),
    .ctl   (e_tag.ctl),
    .mv    (e_mv),
    .den   (e_den),
    .from  (e_tag.sy),
    .to    (e_tag.ey),
    .done  (y_v),
    .point (y_pt)
  );

  // merge: output register plus skid entry
  logic                 pop;
  logic signed [CB-1:0] out_x, out_y, skid_x, skid_y;

  assign pop = out_v && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (pop) begin
        skid_v <= 1'b0;
      end
    end else if (x_v) begin
      if (!out_v || pop) begin
        out_v <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end else if (pop) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (pop) begin
        out_x <= skid_x;
        out_y <= skid_y;
      end
    end else if (x_v) begin
      if (!out_v || pop) begin
        out_x <= x_pt;
        out_y <= y_pt;
      end else begin
        skid_x <= x_pt;
        skid_y <= y_pt;
      end
    end
  end

  assign result.valid   = out_v;
  assign result.point_x = out_x;
  assign result.point_y = out_y;

  `ECI_ASSERT_IMPL(a_skid_needs_out, skid_v, out_v, "skid entry full while output empty")
  `ECI_ASSERT_IMPL(a_skid_blocks, skid_v, !item.ready, "input taken while skid entry full")
  `ECI_ASSERT_NEXT(a_skid_stays_empty, !skid_v && !(out_v && !result.ready), !skid_v, "skid filled without a stalled output")
  `ECI_ASSERT_IMPL(a_lanes_aligned, 1'b1, x_v == y_v, "coordinate lanes out of step")
  `ECI_ASSERT_RST(a_reset_clear, !out_v && !skid_v, "output stage not cleared by reset")

endmodule

// ===== verif/eci_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eci_checker
// Watches the item and result channels of the easing curve interpolator.
// Each item transfer is run through a behavioral model of the curves and the
// point it gives is queued. Each result transfer is checked against the oldest
// queued point, coordinate by coordinate.
// ----------------------------------------------------------------------------
module eci_checker (
  input  logic clk,
  input  logic rst,
  eci_in_if    item,
  eci_out_if   result,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } point_t;

  point_t points_due[$];

  function automatic longint sine_half(longint a);
    longint q;
    if (a > 32768) a = 32768;
    q = a * (32768 - a);
    return (longint'(65535) * 4 * q) / (longint'(5) * (longint'(1) << 28) - q);
  endfunction

  function automatic longint cosine_half(longint a);
    if (a > 32768) a = 32768;
    if (a <= 16384) return sine_half(a + 16384);
    return -sine_half(a - 16384);
  endfunction

  function automatic longint ease_coord(logic [2:0] fn, longint from, longint to,
                                        longint p, longint m);
    longint d, h, t, half, ang;
    d = to - from;
    h = d / 2;
    case (fn)
      eci_pkg::FN_QUAD_IN: begin
        t = p * 100 / m;
        return d * t * t / 10000 + from;
      end
      eci_pkg::FN_QUAD_OUT: begin
        t = p * 100 / m;
        return (-d * t) * (t - 200) / 10000 + from;
      end
      eci_pkg::FN_QUAD_INOUT: begin
        half = m / 2;
        if (half == 0) return from;
        t = p * 100 / half;
        if (t < 100) return h * t * t / 10000 + from;
        t = t - 100;
        return (-h) * (t * (t - 200) - 10000) / 10000 + from;
      end
      eci_pkg::FN_SINE_IN: begin
        ang = (65536 * p / m) / 4;
        return (-h) * cosine_half(ang) / 32767 + d + from;
      end
      eci_pkg::FN_SINE_OUT: begin
        ang = (65536 * p / m) / 4;
        return h * sine_half(ang) / 32767 + from;
      end
      eci_pkg::FN_SINE_INOUT: begin
        ang = (65536 * p / m) / 2;
        return (-h) * (cosine_half(ang) - 65535) / 65535 + from;
      end
      default: return from + d * p / m;
    endcase
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic point_t eased_point(logic [2:0] fn, logic [15:0] p,
                                         logic [15:0] m, logic signed [15:0] sx,
                                         logic signed [15:0] sy,
                                         logic signed [15:0] ex,
                                         logic signed [15:0] ey);
    point_t pt;
    if (p >= m) begin
      pt.x = ex;
      pt.y = ey;
    end else begin
      pt.x = clamp16(ease_coord(fn, sx, ex, p, m));
      pt.y = clamp16(ease_coord(fn, sy, ey, p, m));
    end
    return pt;
  endfunction

  always @(posedge clk) begin
    point_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (item.valid && item.ready)
        points_due.push_back(eased_point(item.func, item.progress, item.progress_max,
                                         item.start_x, item.start_y,
                                         item.end_x, item.end_y));
      if (result.valid && result.ready) begin
        if (points_due.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result transfer: x=%0d y=%0d",
                     result.point_x, result.point_y);
          fail_count <= fail_count + 1;
        end else begin
          want = points_due.pop_front();
          if (want.x !== result.point_x || want.y !== result.point_y) begin
            if (fail_count < 10)
              $display("point mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                       want.x, want.y, result.point_x, result.point_y);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending = points_due.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random easing requests into the interpolator with
// random idle bursts on both channels and one long result stall, and reports
// the verdict from the checker's failure count and pending points.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [2:0] FN_SPARE = 3'd7;
  localparam int RANDOM_ITEMS = 630;
  localparam int CALM_ITEMS = 100;
  localparam int DRAIN_CYCLES = 140;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic calm = 1'b0;
  int   sent = 0;
  int   cycles = 0;
  int   fail_count;
  int   pending;

  eci_in_if  item ();
  eci_out_if result ();

  always #2 clk = ~clk;

  easing_curve_interpolator_unit u_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .result(result)
  );

  eci_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .result    (result),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("easing_curve_interpolator_unit verification failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off, none in the calm phase
  initial begin
    int n;
    result.ready = 1'b1;
    @(negedge rst);
    wait (sent >= 120);
    @(posedge clk);
    result.ready <= 1'b0;
    repeat (400) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
        result.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        result.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  task automatic send_item(logic [2:0] fn, logic [15:0] p, logic [15:0] m,
                           logic [15:0] sx, logic [15:0] sy,
                           logic [15:0] ex, logic [15:0] ey);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 12);
      item.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    item.valid        <= 1'b1;
    item.func         <= fn;
    item.progress     <= p;
    item.progress_max <= m;
    item.start_x      <= sx;
    item.start_y      <= sy;
    item.end_x        <= ex;
    item.end_y        <= ey;
    do @(posedge clk); while (!item.ready);
    sent++;
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 200) - 100);
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    logic [2:0]  fn;
    logic [15:0] p, m;
    item.valid = 1'b0;
    item.func = eci_pkg::FN_LINEAR;
    item.progress = '0;
    item.progress_max = '0;
    item.start_x = '0;
    item.start_y = '0;
    item.end_x = '0;
    item.end_y = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: finished cases, zero half-maximum, extremes per curve
    send_item(eci_pkg::FN_LINEAR, 16'd0, 16'd0, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_item(eci_pkg::FN_SINE_IN, 16'hffff, 16'hffff, 16'h1234, 16'h8000, 16'h8000,
              16'h7fff);
    send_item(eci_pkg::FN_QUAD_INOUT, 16'd0, 16'd1, 16'h8000, 16'h7fff, 16'h7fff,
              16'h8000);
    send_item(eci_pkg::FN_QUAD_OUT, 16'hffff, 16'd5, 16'h0000, 16'h0000, 16'h7fff,
              16'h8000);
    for (int f = 0; f < 8; f++) begin
      send_item(3'(f), 16'd1, 16'd3, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
      send_item(3'(f), 16'hfffe, 16'hffff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    end
    send_item(FN_SPARE, 16'h7fff, 16'hffff, 16'h0000, 16'hffff, 16'h8000, 16'h0001);
    send_item(eci_pkg::FN_SINE_INOUT, 16'h8000, 16'hffff, 16'h8000, 16'h8000, 16'h7fff,
              16'h7fff);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      fn = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 4))
        0: m = 16'($urandom_range(0, 8));
        1: m = 16'hffff;
        default: m = 16'($urandom());
      endcase
      if ($urandom_range(0, 7) == 0) p = 16'($urandom());
      else if (m == 0) p = '0;
      else p = 16'($urandom_range(0, m - 1));
      send_item(fn, p, m, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    end
    item.valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("easing_curve_interpolator_unit verification clean");
    end else begin
      $display("easing_curve_interpolator_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/eci_pkg.sv
src/eci_ifs.sv
src/eci_div.sv
src/eci_lane.sv
src/easing_curve_interpolator_unit.sv
verif/eci_checker.sv
verif/tb.sv
